### hw/rtl/dsa_pkg.sv
// Shared types, command codes and the power-of-ten table for the scaled decimal ALU.
// No dependencies.
package dsa_pkg;

  localparam int unsigned MagW  = 56;
  localparam int unsigned DigW  = 4;
  localparam int unsigned LimbW = 28;
  localparam int unsigned FacW  = 4 * LimbW;
  localparam int unsigned ProdW = MagW + FacW;
  localparam int unsigned PowN  = 31;

  typedef enum logic [2:0] {
    CMD_ADD = 3'd0,
    CMD_SUB = 3'd1,
    CMD_MUL = 3'd2,
    CMD_DIV = 3'd3,
    CMD_CMP = 3'd4,
    CMD_RED = 3'd5
  } cmd_e;

  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef struct packed {
    logic [2:0]      command;
    logic [MagW-1:0] a_magnitude;
    logic [DigW-1:0] a_digits;
    logic            a_negative;
    logic [MagW-1:0] b_magnitude;
    logic [DigW-1:0] b_digits;
    logic            b_negative;
    logic [DigW-1:0] target_digits;
  } in_t;

  typedef struct packed {
    logic [MagW-1:0] r_magnitude;
    logic [DigW-1:0] r_digits;
    logic            r_negative;
    logic [1:0]      order;
    logic            overflow;
  } out_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic            sub_mode;
    logic            sign_x;
    logic            sign_y;
    logic            swap;
    logic [DigW-1:0] digits;
  } ctl_t;

  typedef struct packed {
    logic [2:0]      cmd;
    logic            sign;
    logic [DigW-1:0] digits;
    logic [1:0]      order;
  } res_t;

  typedef logic [FacW-1:0] pow_tab_t [PowN];

  function automatic pow_tab_t gen_pow10();
    pow_tab_t t;
    t[0] = FacW'(1);
    for (int i = 1; i < PowN; i++) begin
      t[i] = FacW'(t[i-1] * FacW'(10));
    end
    return t;
  endfunction

  localparam pow_tab_t POW10 = gen_pow10();

endpackage

### hw/rtl/dsa_decode.sv
// Input stage: picks multiplier operands, addend and divisor for each command.
// Depends on dsa_pkg.
module dsa_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  dsa_pkg::in_t                data_i,
  output logic                        valid_o,
  output logic [dsa_pkg::MagW-1:0]    mag_o,
  output logic [dsa_pkg::FacW-1:0]    fac_o,
  output logic [dsa_pkg::MagW-1:0]    other_o,
  output logic [dsa_pkg::MagW-1:0]    div_o,
  output dsa_pkg::ctl_t               ctl_o
);
  import dsa_pkg::*;

  logic [MagW-1:0] am, bm;
  logic [DigW-1:0] ad, bd, s, mn;
  logic            an, bn, bne;
  logic [4:0]      e_ab, e_ba, e_div, e_sa, e_red;
  logic [MagW-1:0] mag_d, other_d, div_d;
  logic [FacW-1:0] fac_d;
  ctl_t            ctl_d;
  logic            valid_q;
  logic [MagW-1:0] mag_q, other_q, div_q;
  logic [FacW-1:0] fac_q;
  ctl_t            ctl_q;

  always_comb begin
    am    = data_i.a_magnitude;
    bm    = data_i.b_magnitude;
    ad    = data_i.a_digits;
    bd    = data_i.b_digits;
    an    = data_i.a_negative && (am != '0);
    bn    = data_i.b_negative && (bm != '0);
    s     = (ad > bd) ? ad : bd;
    mn    = (ad > bd) ? bd : ad;
    e_ab  = 5'({1'b0, bd} - {1'b0, ad});
    e_ba  = 5'({1'b0, ad} - {1'b0, bd});
    e_sa  = 5'({1'b0, s} - {1'b0, ad});
    e_div = 5'({1'b0, bd} + {1'b0, s} - {1'b0, ad});
    e_red = 5'({1'b0, ad} - {1'b0, data_i.target_digits});
    bne   = bn ^ ((data_i.command == CMD_SUB) && (bm != '0));

    mag_d   = am;
    fac_d   = POW10[0];
    other_d = '0;
    div_d   = POW10[0][MagW-1:0];
    ctl_d   = '0;
    ctl_d.cmd    = data_i.command;
    ctl_d.digits = s;

    case (data_i.command)
      CMD_ADD, CMD_SUB, CMD_CMP: begin
        if (ad < bd) begin
          mag_d        = am;
          fac_d        = POW10[e_ab];
          other_d      = bm;
          ctl_d.sign_x = an;
          ctl_d.sign_y = bne;
          ctl_d.swap   = 1'b0;
        end else begin
          mag_d        = bm;
          fac_d        = POW10[e_ba];
          other_d      = am;
          ctl_d.sign_x = bne;
          ctl_d.sign_y = an;
          ctl_d.swap   = 1'b1;
        end
        ctl_d.sub_mode = (an != bne);
      end
      CMD_MUL: begin
        fac_d        = {{(FacW-MagW){1'b0}}, bm};
        div_d        = POW10[{1'b0, mn}][MagW-1:0];
        ctl_d.sign_x = an ^ bn;
      end
      CMD_DIV: begin
        if (bm == '0) begin
          fac_d        = POW10[e_sa];
          ctl_d.sign_x = an;
        end else begin
          fac_d        = POW10[e_div];
          div_d        = bm;
          ctl_d.sign_x = an ^ bn;
        end
      end
      CMD_RED: begin
        ctl_d.sign_x = an;
        if (data_i.target_digits < ad) begin
          div_d        = POW10[e_red][MagW-1:0];
          other_d      = POW10[e_red][MagW:1];
          ctl_d.digits = data_i.target_digits;
        end else begin
          ctl_d.digits = ad;
        end
      end
      default: begin
        mag_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q   <= mag_d;
      fac_q   <= fac_d;
      other_q <= other_d;
      div_q   <= div_d;
      ctl_q   <= ctl_d;
    end
  end

  assign valid_o = valid_q;
  assign mag_o   = mag_q;
  assign fac_o   = fac_q;
  assign other_o = other_q;
  assign div_o   = div_q;
  assign ctl_o   = ctl_q;

endmodule

### hw/rtl/dsa_mul.sv
// Pipelined 56 x 112 multiplier: partial products of 28-bit limbs, then three adder stages.
// Depends on dsa_pkg.
module dsa_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [dsa_pkg::MagW-1:0]    mag_i,
  input  logic [dsa_pkg::FacW-1:0]    fac_i,
  input  logic [dsa_pkg::MagW-1:0]    other_i,
  input  logic [dsa_pkg::MagW-1:0]    div_i,
  input  dsa_pkg::ctl_t               ctl_i,
  output logic                        valid_o,
  output logic [dsa_pkg::ProdW-1:0]   prod_o,
  output logic [dsa_pkg::MagW-1:0]    other_o,
  output logic [dsa_pkg::MagW-1:0]    div_o,
  output dsa_pkg::ctl_t               ctl_o
);
  import dsa_pkg::*;

  localparam int unsigned Stages = 4;
  localparam int unsigned PpW    = 2 * LimbW;
  localparam int unsigned HalfW  = PpW + LimbW + 1;
  localparam int unsigned RowW   = HalfW + PpW;

  typedef struct packed {
    logic [MagW-1:0] other;
    logic [MagW-1:0] div;
    ctl_t            ctl;
  } side_t;

  logic [Stages-1:0] valid_q;
  side_t             side_q [Stages];
  logic [PpW-1:0]    pp_q [2][4];
  logic [HalfW-1:0]  lo_q [2], hi_q [2];
  logic [RowW-1:0]   row_q [2];
  logic [ProdW-1:0]  prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Stages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= '{other: other_i, div: div_i, ctl: ctl_i};
      for (int k = 1; k < Stages; k++) begin
        side_q[k] <= side_q[k-1];
      end
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 4; j++) begin
          pp_q[i][j] <= mag_i[i*LimbW +: LimbW] * fac_i[j*LimbW +: LimbW];
        end
        lo_q[i] <= HalfW'(pp_q[i][0]) + (HalfW'(pp_q[i][1]) << LimbW);
        hi_q[i] <= HalfW'(pp_q[i][2]) + (HalfW'(pp_q[i][3]) << LimbW);
        row_q[i] <= RowW'(lo_q[i]) + (RowW'(hi_q[i]) << PpW);
      end
      prod_q <= ProdW'(row_q[0]) + (ProdW'(row_q[1]) << LimbW);
    end
  end

  assign valid_o = valid_q[Stages-1];
  assign prod_o  = prod_q;
  assign other_o = side_q[Stages-1].other;
  assign div_o   = side_q[Stages-1].div;
  assign ctl_o   = side_q[Stages-1].ctl;

endmodule

### hw/rtl/dsa_combine.sv
// Add/subtract/compare stage: forms the dividend, the result sign and the compare answer.
// Depends on dsa_pkg.
module dsa_combine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [dsa_pkg::ProdW-1:0]   prod_i,
  input  logic [dsa_pkg::MagW-1:0]    other_i,
  input  logic [dsa_pkg::MagW-1:0]    div_i,
  input  dsa_pkg::ctl_t               ctl_i,
  output logic                        valid_o,
  output logic [dsa_pkg::ProdW-1:0]   num_o,
  output logic [dsa_pkg::MagW-1:0]    div_o,
  output dsa_pkg::res_t               res_o
);
  import dsa_pkg::*;

  logic [ProdW-1:0] oth, num_d, num_q;
  logic             gt, eq, a_gt, a_sign;
  res_t             res_d, res_q;
  logic [MagW-1:0]  div_q;
  logic             valid_q;

  always_comb begin
    oth    = ProdW'(other_i);
    gt     = prod_i > oth;
    eq     = prod_i == oth;
    a_gt   = ctl_i.swap ? (!gt && !eq) : gt;
    a_sign = ctl_i.swap ? ctl_i.sign_y : ctl_i.sign_x;

    res_d        = '0;
    res_d.cmd    = ctl_i.cmd;
    res_d.digits = ctl_i.digits;
    res_d.sign   = ctl_i.sign_x;
    if (!ctl_i.sub_mode) begin
      num_d = prod_i + oth;
    end else if (gt || eq) begin
      num_d = prod_i - oth;
    end else begin
      num_d      = oth - prod_i;
      res_d.sign = ctl_i.sign_y;
    end

    if (ctl_i.sign_x != ctl_i.sign_y) begin
      res_d.order = a_sign ? ORD_LT : ORD_GT;
    end else if (eq) begin
      res_d.order = ORD_EQ;
    end else begin
      res_d.order = (a_gt ^ a_sign) ? ORD_GT : ORD_LT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      div_q <= div_i;
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign div_o   = div_q;
  assign res_o   = res_q;

endmodule

### hw/rtl/dsa_div.sv
// Pipelined restoring divider: range check stage, then one quotient bit per stage.
// Depends on dsa_pkg.
module dsa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [dsa_pkg::ProdW-1:0]   num_i,
  input  logic [dsa_pkg::MagW-1:0]    div_i,
  input  dsa_pkg::res_t               res_i,
  output logic                        valid_o,
  output logic [dsa_pkg::MagW-1:0]    quo_o,
  output logic                        ovf_o,
  output dsa_pkg::res_t               res_o
);
  import dsa_pkg::*;

  localparam int unsigned Steps = MagW;
  localparam int unsigned HiW   = ProdW - MagW;

  logic [Steps:0]  valid_q;
  logic [MagW-1:0] rem_q [Steps+1];
  logic [MagW-1:0] low_q [Steps+1];
  logic [MagW-1:0] dv_q  [Steps+1];
  logic            ovf_q [Steps+1];
  res_t            res_q [Steps+1];
  logic [MagW:0]   trial [Steps];
  logic [MagW:0]   diff  [Steps];

  always_comb begin
    for (int k = 0; k < Steps; k++) begin
      trial[k] = {rem_q[k], low_q[k][MagW-1]};
      diff[k]  = trial[k] - {1'b0, dv_q[k]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[Steps-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= num_i[2*MagW-1:MagW];
      low_q[0] <= num_i[MagW-1:0];
      dv_q[0]  <= div_i;
      ovf_q[0] <= num_i[ProdW-1:MagW] >= HiW'(div_i);
      res_q[0] <= res_i;
      for (int k = 0; k < Steps; k++) begin
        rem_q[k+1] <= diff[k][MagW] ? trial[k][MagW-1:0] : diff[k][MagW-1:0];
        low_q[k+1] <= {low_q[k][MagW-2:0], !diff[k][MagW]};
        dv_q[k+1]  <= dv_q[k];
        ovf_q[k+1] <= ovf_q[k];
        res_q[k+1] <= res_q[k];
      end
    end
  end

  assign valid_o = valid_q[Steps];
  assign quo_o   = low_q[Steps];
  assign ovf_o   = ovf_q[Steps];
  assign res_o   = res_q[Steps];

endmodule

### hw/rtl/decimal_scaled_alu_core.sv
// Scaled decimal ALU: add, subtract, multiply, divide, compare and round-half-up reduce.
// Takes one transfer per cycle sustained while the output buffer is not full.
// Path: decode, 4-stage multiplier, combine, 57-stage divider, then a 2-entry output
// buffer that lets the pipeline keep taking transfers while a result waits; the whole
// pipeline holds only when that buffer is full. Reset (async, active low) clears valids.
// Depends on dsa_pkg, dsa_decode, dsa_mul, dsa_combine, dsa_div.
module decimal_scaled_alu_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  dsa_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dsa_pkg::out_t  out_data_o
);
  import dsa_pkg::*;

  logic            en;
  logic            v0, v1, v2, v3;
  logic [MagW-1:0] mag0, oth0, div0, oth1, div1, div2, quo3;
  logic [FacW-1:0] fac0;
  logic [ProdW-1:0] prod1, num2;
  ctl_t            ctl0, ctl1;
  res_t            res2, res3;
  logic            ovf3;
  out_t            fmt;
  out_t            buf_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  dsa_decode u_decode (
    .clk_i, .rst_ni, .en_i(en), .valid_i(in_valid_i), .data_i(in_data_i),
    .valid_o(v0), .mag_o(mag0), .fac_o(fac0), .other_o(oth0), .div_o(div0), .ctl_o(ctl0)
  );

  dsa_mul u_mul (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v0), .mag_i(mag0), .fac_i(fac0),
    .other_i(oth0), .div_i(div0), .ctl_i(ctl0),
    .valid_o(v1), .prod_o(prod1), .other_o(oth1), .div_o(div1), .ctl_o(ctl1)
  );

  dsa_combine u_combine (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1), .prod_i(prod1), .other_i(oth1),
    .div_i(div1), .ctl_i(ctl1),
    .valid_o(v2), .num_o(num2), .div_o(div2), .res_o(res2)
  );

  dsa_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v2), .num_i(num2), .div_i(div2), .res_i(res2),
    .valid_o(v3), .quo_o(quo3), .ovf_o(ovf3), .res_o(res3)
  );

  always_comb begin
    fmt = '0;
    case (res3.cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_RED: begin
        fmt.r_magnitude = ovf3 ? {MagW{1'b1}} : quo3;
        fmt.r_digits    = res3.digits;
        fmt.r_negative  = res3.sign && (fmt.r_magnitude != '0);
        fmt.overflow    = ovf3;
      end
      CMD_CMP: begin
        fmt.order = res3.order;
      end
      default: begin
        fmt = '0;
      end
    endcase
  end

  assign en   = (cnt_q != 2'd2);
  assign push = v3 && en;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_q] <= fmt;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = buf_q[rd_q];

endmodule
